[rtl/core/bia_pkg.sv]
// Shared types and constants for the bitmap identifier allocator.
// Depends on nothing; every other file imports it.
`default_nettype none

package bia_pkg;

  localparam int MAX_IDS   = 1024;
  localparam int WORD_BITS = 64;
  localparam int NUM_WORDS = (MAX_IDS + WORD_BITS - 1) / WORD_BITS;

  localparam int ID_W       = 16;
  localparam int COUNT_W    = 11;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 16;

  localparam int BIT_W    = $clog2(WORD_BITS);
  localparam int WIDX_W   = $clog2(NUM_WORDS);
  localparam int ID_BIT_W = BIT_W + WIDX_W;
  localparam int ROOM_W   = ID_W + 1;

  localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_ID = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_ID_COUNT = CFG_ADDR_W'(1);

  typedef enum logic [1:0] {
    KIND_ANY,
    KIND_SPEC,
    KIND_FREE,
    KIND_RSVD
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_RANGE,
    ST_TAKEN
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             pass;
    logic             at_start;
    logic             at_last;
    logic [BIT_W-1:0] start_bit;
    logic [BIT_W-1:0] last_bit;
  } bia_scan_ctl_t;

endpackage

`default_nettype wire

[rtl/core/bia_if.sv]
// Handshake channels of the allocator: request, result and register write.
// Depends on bia_pkg.
`default_nettype none

interface bia_in_if import bia_pkg::*; ();
  logic              valid;
  logic              ready;
  kind_t             kind;
  logic [ID_W-1:0]   req_id;
  modport source (output valid, kind, req_id, input ready);
  modport sink   (input valid, kind, req_id, output ready);
endinterface

interface bia_out_if import bia_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ID_W-1:0]    result_id;
  status_t            status;
  logic [COUNT_W-1:0] used_count;
  modport source (output valid, result_id, status, used_count, input ready);
  modport sink   (input valid, result_id, status, used_count, output ready);
endinterface

interface bia_cfg_if import bia_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

[rtl/core/bia_scan.sv]
// Masked find-first-free over one bitmap word.
// Depends on bia_pkg.
`default_nettype none

module bia_scan import bia_pkg::*; (
  input  wire logic [WORD_BITS-1:0] word,
  input  wire bia_scan_ctl_t        ctl,
  output logic                      found,
  output logic [BIT_W-1:0]          hit_bit
);

  logic [WORD_BITS-1:0] ones;
  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] avail;

  assign ones    = '1;
  assign lo_mask = ones << ctl.start_bit;
  assign hi_mask = ones >> (BIT_W'(WORD_BITS - 1) - ctl.last_bit);

  always_comb begin
    mask = ones;
    if (ctl.at_start) begin
      mask = ctl.pass ? ~lo_mask : lo_mask;
    end
    if (ctl.at_last) begin
      mask = mask & hi_mask;
    end
  end

  assign avail = ~word & mask;
  assign found = |avail;

  always_comb begin
    hit_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        hit_bit = BIT_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/bitmap_id_allocator.sv]
// Bitmap identifier allocator, next-fit search over 64-bit used-bit words.
// Allocate-given, free, and allocate-any on a full range go from execute to done;
// otherwise allocate-any scans 1 to NUM_WORDS+1 words, one per cycle, in the single
// find-first-free unit. A new request is accepted only back in the idle state.
// Reset (synchronous, active low): first_id 0, id_count 1024; bitmap, count and search
// position cleared at once through per-word valid bits, as on a register write.
`default_nettype none

module bitmap_id_allocator import bia_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  bia_cfg_if.sink   cfg_ch,
  bia_in_if.sink    in_ch,
  bia_out_if.source out_ch
);

  state_t                 state_r, state_nxt;
  logic [ID_W-1:0]        first_id_r;
  logic [COUNT_W-1:0]     id_count_r;
  kind_t                  kind_r;
  logic [ID_W-1:0]        req_r;
  logic [ID_BIT_W-1:0]    start_r, start_nxt;
  logic [WIDX_W-1:0]      scan_w_r, scan_w_nxt;
  logic                   pass_r, pass_nxt;
  logic [ID_W-1:0]        res_id_r, res_id_nxt;
  status_t                res_st_r, res_st_nxt;
  logic [COUNT_W-1:0]     used_r, used_nxt;
  logic [ID_BIT_W-1:0]    search_r, search_nxt;
  logic [WORD_BITS-1:0]   words_r [NUM_WORDS];
  logic [NUM_WORDS-1:0]   vld_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]        out_id_r;
  status_t                out_st_r;
  logic [COUNT_W-1:0]     out_used_r;

  logic                   in_acc;
  logic                   cfg_hit;
  logic                   out_free;
  logic [ROOM_W-1:0]      room;
  logic [COUNT_W-1:0]     lim;
  logic [COUNT_W-1:0]     size_c;
  logic [ID_W-1:0]        off;
  logic                   in_rng;
  logic [ID_BIT_W-1:0]    bit_addr;
  logic [WIDX_W-1:0]      req_w;
  logic [BIT_W-1:0]       req_b;
  logic                   full;
  logic [ID_BIT_W-1:0]    start_c;
  logic [COUNT_W-1:0]     last_idx;
  logic [WIDX_W-1:0]      last_w;
  logic [WIDX_W-1:0]      rd_idx;
  logic [WORD_BITS-1:0]   rd_word;
  bia_scan_ctl_t          scan_ctl;
  logic                   found;
  logic [BIT_W-1:0]       hit_bit;
  logic [ID_BIT_W-1:0]    hit_addr;
  logic                   wr_en;
  logic [WORD_BITS-1:0]   wr_word;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid & in_ch.ready;
  assign cfg_hit      = cfg_ch.valid & cfg_ch.ready &
                        ((cfg_ch.addr == CFG_FIRST_ID) || (cfg_ch.addr == CFG_ID_COUNT));
  assign out_free     = ~out_valid_r | out_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.result_id  = out_id_r;
  assign out_ch.status     = out_st_r;
  assign out_ch.used_count = out_used_r;

  assign room   = (ROOM_W'(1) << ID_W) - {1'b0, first_id_r};
  assign lim    = (id_count_r > COUNT_W'(MAX_IDS)) ? COUNT_W'(MAX_IDS) : id_count_r;
  assign size_c = (ROOM_W'(lim) > room) ? COUNT_W'(room) : lim;

  assign off      = req_r - first_id_r;
  assign in_rng   = (req_r >= first_id_r) && (off < ID_W'(size_c));
  assign bit_addr = off[ID_BIT_W-1:0];
  assign req_w    = bit_addr[ID_BIT_W-1:BIT_W];
  assign req_b    = bit_addr[BIT_W-1:0];
  assign full     = (used_r >= size_c);
  assign start_c  = (COUNT_W'(search_r) < size_c) ? search_r : '0;
  assign last_idx = size_c - COUNT_W'(1);
  assign last_w   = last_idx[ID_BIT_W-1:BIT_W];

  assign rd_idx  = (state_r == S_SCAN) ? scan_w_r : req_w;
  assign rd_word = vld_r[rd_idx] ? words_r[rd_idx] : '0;

  assign scan_ctl.pass      = pass_r;
  assign scan_ctl.at_start  = (scan_w_r == start_r[ID_BIT_W-1:BIT_W]);
  assign scan_ctl.at_last   = (scan_w_r == last_w);
  assign scan_ctl.start_bit = start_r[BIT_W-1:0];
  assign scan_ctl.last_bit  = last_idx[BIT_W-1:0];

  bia_scan u_scan (
    .word    (rd_word),
    .ctl     (scan_ctl),
    .found   (found),
    .hit_bit (hit_bit)
  );

  assign hit_addr = {scan_w_r, hit_bit};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = (kind_r == KIND_ANY && !full) ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        if (found || (pass_r && scan_ctl.at_start)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    start_nxt     = start_r;
    scan_w_nxt    = scan_w_r;
    pass_nxt      = pass_r;
    res_id_nxt    = res_id_r;
    res_st_nxt    = res_st_r;
    used_nxt      = used_r;
    search_nxt    = search_r;
    wr_en         = 1'b0;
    wr_word       = rd_word;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    unique case (state_r)
      S_IDLE: begin
        if (cfg_hit) begin
          used_nxt   = '0;
          search_nxt = '0;
        end
      end
      S_EXEC: begin
        res_id_nxt = '0;
        res_st_nxt = ST_OK;
        unique case (kind_r)
          KIND_ANY: begin
            if (full) begin
              res_st_nxt = ST_FULL;
            end else begin
              start_nxt  = start_c;
              scan_w_nxt = start_c[ID_BIT_W-1:BIT_W];
              pass_nxt   = 1'b0;
            end
          end
          KIND_SPEC: begin
            priority if (full) begin
              res_st_nxt = ST_FULL;
            end else if (!in_rng) begin
              res_st_nxt = ST_RANGE;
            end else if (rd_word[req_b]) begin
              res_st_nxt = ST_TAKEN;
            end else begin
              wr_en          = 1'b1;
              wr_word[req_b] = 1'b1;
              used_nxt       = used_r + COUNT_W'(1);
              res_id_nxt     = req_r;
            end
          end
          KIND_FREE: begin
            priority if (!in_rng) begin
              res_st_nxt = ST_RANGE;
            end else if (!rd_word[req_b]) begin
              res_st_nxt = ST_TAKEN;
            end else begin
              wr_en          = 1'b1;
              wr_word[req_b] = 1'b0;
              if (used_r != '0) begin
                used_nxt = used_r - COUNT_W'(1);
              end
              res_id_nxt = req_r;
            end
          end
          KIND_RSVD: begin
            res_st_nxt = ST_RANGE;
          end
          default: res_st_nxt = ST_RANGE;
        endcase
      end
      S_SCAN: begin
        priority if (found) begin
          wr_en            = 1'b1;
          wr_word[hit_bit] = 1'b1;
          used_nxt         = used_r + COUNT_W'(1);
          search_nxt       = (COUNT_W'(hit_addr) + COUNT_W'(1) == size_c) ? '0 :
                             hit_addr + ID_BIT_W'(1);
          res_id_nxt       = ID_W'(hit_addr) + first_id_r;
        end else if (pass_r && scan_ctl.at_start) begin
          res_st_nxt = ST_FULL;
        end else if (!pass_r && scan_ctl.at_last) begin
          pass_nxt   = 1'b1;
          scan_w_nxt = '0;
        end else begin
          scan_w_nxt = scan_w_r + WIDX_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: out_valid_nxt = out_valid_r & ~out_ch.ready;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_id_r  <= '0;
      id_count_r  <= COUNT_W'(MAX_IDS);
      used_r      <= '0;
      search_r    <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      search_r    <= search_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_hit) begin
        vld_r <= '0;
        if (cfg_ch.addr == CFG_FIRST_ID) begin
          first_id_r <= cfg_ch.data[ID_W-1:0];
        end else begin
          id_count_r <= cfg_ch.data[COUNT_W-1:0];
        end
      end else if (wr_en) begin
        vld_r[rd_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    start_r  <= start_nxt;
    scan_w_r <= scan_w_nxt;
    pass_r   <= pass_nxt;
    res_id_r <= res_id_nxt;
    res_st_r <= res_st_nxt;
    if (in_acc) begin
      kind_r <= in_ch.kind;
      req_r  <= in_ch.req_id;
    end
    if (wr_en) begin
      words_r[rd_idx] <= wr_word;
    end
    if (state_r == S_DONE && out_free) begin
      out_id_r   <= res_id_r;
      out_st_r   <= res_st_r;
      out_used_r <= used_r;
    end
  end

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= size_c)
    else $error("used count exceeds range size");

  a_scan_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_w_r <= last_w))
    else $error("scan word beyond last word of range");

  a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && found) |=> (used_r == COUNT_W'($past(used_r) + COUNT_W'(1))))
    else $error("allocation did not advance used count");

  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (used_r == '0 && vld_r == '0 && search_r == '0))
    else $error("register write did not clear allocator state");
`endif

endmodule

`default_nettype wire
